// ===== src/pmt_sp_pkg.sv =====
package pmt_sp_pkg;

	// header byte offsets within the section
	localparam logic [11:0] OFF_TABLE_ID = 12'd0;
	localparam logic [11:0] OFF_LEN_HI   = 12'd1;
	localparam logic [11:0] OFF_LEN_LO   = 12'd2;
	localparam logic [11:0] OFF_PROG_HI  = 12'd3;
	localparam logic [11:0] OFF_PROG_LO  = 12'd4;
	localparam logic [11:0] OFF_INFO_HI  = 12'd10;
	localparam logic [11:0] OFF_INFO_LO  = 12'd11;
	localparam logic [11:0] OFF_LOOP     = 12'd12;
	localparam logic [11:0] OFF_MAX      = 12'hFFF;

	// byte positions inside one stream entry
	localparam logic [12:0] ENT_TYPE    = 13'd0;
	localparam logic [12:0] ENT_PID_HI  = 13'd1;
	localparam logic [12:0] ENT_PID_LO  = 13'd2;
	localparam logic [12:0] ENT_LEN_HI  = 13'd3;
	localparam logic [12:0] ENT_LEN_LO  = 13'd4;
	localparam logic [12:0] ENT_TAG     = 13'd5;
	localparam logic [12:0] ENT_HDR_LEN = 13'd5;

	localparam logic [7:0] TYPE_VIDEO   = 8'd2;
	localparam logic [7:0] TYPE_AUDIO   = 8'd3;
	localparam logic [7:0] TYPE_PRIVATE = 8'd6;
	localparam logic [7:0] TAG_TELETEXT = 8'd86;
	localparam logic [7:0] COUNT_MAX    = 8'hFF;

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam int DATA_W = 104;

	typedef struct packed {
		logic        kind;
		logic        last;
		logic [7:0]  stype;
		logic [12:0] pid;
		logic [11:0] es_len;
		logic [7:0]  tag;
		logic [15:0] prog;
		logic [11:0] slen;
		logic [12:0] apid;
		logic [12:0] vpid;
		logic        ttx;
		logic [7:0]  cnt;
	} rec_t;

	// records caused by one input byte, first one leaves first
	typedef struct packed {
		logic [1:0] num;
		rec_t       first;
		rec_t       second;
	} pair_t;

endpackage

// ===== src/pmt_sp_core.sv =====
module pmt_sp_core
	import pmt_sp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] section_byte,
	input  logic       last_byte,
	output pair_t      pair
);

	logic [11:0] off_q, len_q, info_q, elen_q;
	logic [15:0] prog_q;
	logic [12:0] es_q, pid_q, apid_q, vpid_q;
	logic [7:0]  etype_q, cnt_q;
	logic        ttx_q, done_q;

	logic [11:0] off_d, len_d, info_d, elen_d;
	logic [15:0] prog_d;
	logic [12:0] es_d, pid_d, apid_d, vpid_d;
	logic [7:0]  etype_d, cnt_d;
	logic        ttx_d, done_d;

	logic [12:0] off_ext, rel, rel_eff, es_next;
	logic        active, ent_hit;
	rec_t        ent_rec, sum_rec;

	assign off_ext = {1'b0, off_q};

	always_comb begin
		len_d   = len_q;
		prog_d  = prog_q;
		info_d  = info_q;
		es_d    = es_q;
		etype_d = etype_q;
		pid_d   = pid_q;
		elen_d  = elen_q;
		apid_d  = apid_q;
		vpid_d  = vpid_q;
		ttx_d   = ttx_q;
		cnt_d   = cnt_q;
		done_d  = done_q;

		unique case (off_q)
			OFF_TABLE_ID: begin
				len_d   = '0;
				prog_d  = '0;
				info_d  = '0;
				es_d    = '0;
				etype_d = '0;
				pid_d   = '0;
				elen_d  = '0;
				apid_d  = '0;
				vpid_d  = '0;
				ttx_d   = 1'b0;
				cnt_d   = '0;
				done_d  = 1'b0;
			end
			OFF_LEN_HI:  len_d  = {section_byte[3:0], 8'h00};
			OFF_LEN_LO:  len_d  = len_q | {4'h0, section_byte};
			OFF_PROG_HI: prog_d = {section_byte, 8'h00};
			OFF_PROG_LO: prog_d = prog_q | {8'h00, section_byte};
			OFF_INFO_HI: info_d = {section_byte[3:0], 8'h00};
			OFF_INFO_LO: begin
				info_d = info_q | {4'h0, section_byte};
				es_d   = {1'b0, OFF_LOOP} + {1'b0, info_q | {4'h0, section_byte}};
			end
			default: ;
		endcase

		// entry loop; header offsets never reach it
		active  = (off_q >= OFF_LOOP) && !done_q && (off_ext >= es_q);
		rel     = off_ext - es_q;
		ent_hit = active && (rel == ENT_TAG);
		es_next = es_q + ENT_HDR_LEN + {1'b0, elen_q};
		rel_eff = rel;

		if (ent_hit) begin
			if (etype_q == TYPE_AUDIO)
				apid_d = pid_q;
			else if (etype_q == TYPE_VIDEO)
				vpid_d = pid_q;
			if (etype_q == TYPE_PRIVATE && section_byte == TAG_TELETEXT)
				ttx_d = 1'b1;
			if (cnt_q != COUNT_MAX)
				cnt_d = cnt_q + 8'd1;
			es_d    = es_next;
			// empty ES info: this tag byte opens the next entry
			rel_eff = (off_ext == es_next) ? ENT_TYPE : ENT_TAG + 13'd1;
		end

		if (active) begin
			unique case (rel_eff)
				ENT_TYPE: begin
					if ({1'b0, es_d} + {1'b0, ENT_HDR_LEN} < {2'b00, len_q})
						etype_d = section_byte;
					else
						done_d = 1'b1;
				end
				ENT_PID_HI: pid_d  = {section_byte[4:0], 8'h00};
				ENT_PID_LO: pid_d  = pid_q | {5'h00, section_byte};
				ENT_LEN_HI: elen_d = {section_byte[3:0], 8'h00};
				ENT_LEN_LO: elen_d = elen_q | {4'h0, section_byte};
				default: ;
			endcase
		end
	end

	always_comb begin
		if (last_byte)
			off_d = '0;
		else if (off_q != OFF_MAX)
			off_d = off_q + 12'd1;
		else
			off_d = off_q;
	end

	always_comb begin
		ent_rec.kind   = KIND_ENTRY;
		ent_rec.last   = !last_byte;
		ent_rec.stype  = etype_q;
		ent_rec.pid    = pid_q;
		ent_rec.es_len = elen_q;
		ent_rec.tag    = section_byte;
		ent_rec.prog   = prog_d;
		ent_rec.slen   = len_d;
		ent_rec.apid   = apid_d;
		ent_rec.vpid   = vpid_d;
		ent_rec.ttx    = ttx_d;
		ent_rec.cnt    = cnt_d;

		sum_rec        = ent_rec;
		sum_rec.kind   = KIND_SUMMARY;
		sum_rec.last   = 1'b1;
		sum_rec.stype  = '0;
		sum_rec.pid    = '0;
		sum_rec.es_len = '0;
		sum_rec.tag    = '0;

		pair.second = sum_rec;
		if (ent_hit) begin
			pair.first = ent_rec;
			pair.num   = last_byte ? 2'd2 : 2'd1;
		end else begin
			pair.first = sum_rec;
			pair.num   = last_byte ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			len_q   <= '0;
			prog_q  <= '0;
			info_q  <= '0;
			es_q    <= '0;
			etype_q <= '0;
			pid_q   <= '0;
			elen_q  <= '0;
			apid_q  <= '0;
			vpid_q  <= '0;
			ttx_q   <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else if (accept) begin
			off_q   <= off_d;
			len_q   <= len_d;
			prog_q  <= prog_d;
			info_q  <= info_d;
			es_q    <= es_d;
			etype_q <= etype_d;
			pid_q   <= pid_d;
			elen_q  <= elen_d;
			apid_q  <= apid_d;
			vpid_q  <= vpid_d;
			ttx_q   <= ttx_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

endmodule

// ===== src/pmt_sp_outbuf.sv =====
module pmt_sp_outbuf
	import pmt_sp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  pair_t pair,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output rec_t  out_rec
);

	logic [1:0] cnt_q;
	rec_t       rec0_q, rec1_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign out_rec   = rec0_q;
	assign pop       = out_valid && out_ready;
	// a new pair fits once the last held record leaves this cycle
	assign room      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= pair.num;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec0_q <= pair.first;
			rec1_q <= pair.second;
		end else if (pop) begin
			rec0_q <= rec1_q;
		end
	end

endmodule

// ===== src/pmt_sp_top.sv =====
// Output: the records that a byte causes are registered in the output buffer on accept.
// Throughput: one byte per cycle while m_tready is high; a byte that yields an entry
//   and a summary record stalls input until the first leaves the single output port.
// Reset: arst_n clears the section offset, all header and entry state and the
//   output buffer count; the block is ready in the first cycle after reset.
module pmt_section_parser_top
	import pmt_sp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // section_byte
	input  logic              s_tlast,   // last_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	// stream_type, elementary_pid, es_info_length, descriptor_tag, program_number,
	// section_length, audio_pid, video_pid, has_teletext, stream_count
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast,   // last_of_run
	output logic              m_tuser    // record_kind
);

	logic  accept;
	pair_t pair;
	rec_t  rec;

	assign accept = s_tvalid && s_tready;

	pmt_sp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.section_byte (s_tdata),
		.last_byte    (s_tlast),
		.pair         (pair)
	);

	pmt_sp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.pair      (pair),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_rec   (rec)
	);

	assign m_tdata = {rec.cnt, rec.ttx, rec.vpid, rec.apid, rec.slen, rec.prog,
	                  rec.tag, rec.es_len, rec.pid, rec.stype};
	assign m_tlast = rec.last;
	assign m_tuser = rec.kind;

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("summary record not last of its run");

	a_entry_counted: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[103:96] != 8'd0)
		else $error("entry record with zero stream count");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output buffer");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("buffered record changed while stalled");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import pmt_sp_pkg::*;

	localparam logic [7:0]  PMT_TABLE_ID = 8'h02;
	localparam int unsigned REL_NONE     = 6;     // past the entry header, nothing to capture
	localparam int          RANDOM_BYTES = 400;
	localparam int          LONG_ENTRIES = 260;

	typedef struct {
		logic [7:0] b;
		logic       fin;
	} sec_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [7:0]        s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;
	logic              m_tuser;

	sec_byte_t pending_bytes[$];
	rec_t      expected_records[$];
	int        err_count = 0;
	int        total_bytes = 0;
	int        bytes_accepted = 0;

	// parser state as predicted
	logic [11:0] pos = '0;
	logic [11:0] slen_hold = '0;
	logic [15:0] prog_hold = '0;
	logic [11:0] pinfo_len = '0;
	logic [12:0] entry_base = '0;
	logic [7:0]  cur_type = '0;
	logic [12:0] cur_pid = '0;
	logic [11:0] cur_es_len = '0;
	logic [12:0] apid_hold = '0;
	logic [12:0] vpid_hold = '0;
	logic        ttx_seen = 1'b0;
	logic [7:0]  n_streams = '0;
	logic        loop_over = 1'b0;

	// sender and receiver pacing
	int tx_burst = 1;
	int tx_gap = 0;
	int rx_mode = 0;
	int rx_left = 0;
	int rx_phase = 0;
	logic [7:0] rx_pat = 8'hFF;

	pmt_section_parser_top dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic rec_t make_record(logic kind, logic [7:0] stype, logic [12:0] pid,
			logic [11:0] es_len, logic [7:0] tag);
		rec_t r;
		r.kind   = kind;
		r.last   = 1'b0;
		r.stype  = stype;
		r.pid    = pid;
		r.es_len = es_len;
		r.tag    = tag;
		r.prog   = prog_hold;
		r.slen   = slen_hold;
		r.apid   = apid_hold;
		r.vpid   = vpid_hold;
		r.ttx    = ttx_seen;
		r.cnt    = n_streams;
		return r;
	endfunction

	task automatic parse_section_byte(input logic [7:0] b, input logic fin);
		rec_t        recs[2];
		int          n;
		int unsigned rel;
		logic [12:0] pos13;
		n = 0;
		pos13 = 13'(pos);
		case (pos)
			OFF_TABLE_ID: begin
				slen_hold = '0;
				prog_hold = '0;
				pinfo_len = '0;
				entry_base = '0;
				cur_type = '0;
				cur_pid = '0;
				cur_es_len = '0;
				apid_hold = '0;
				vpid_hold = '0;
				ttx_seen = 1'b0;
				n_streams = '0;
				loop_over = 1'b0;
			end
			OFF_LEN_HI:  slen_hold = {b[3:0], 8'h00};
			OFF_LEN_LO:  slen_hold = slen_hold | 12'(b);
			OFF_PROG_HI: prog_hold = {b, 8'h00};
			OFF_PROG_LO: prog_hold = prog_hold | 16'(b);
			OFF_INFO_HI: pinfo_len = {b[3:0], 8'h00};
			OFF_INFO_LO: begin
				pinfo_len = pinfo_len | 12'(b);
				entry_base = 13'(OFF_LOOP) + 13'(pinfo_len);
			end
			default: ;
		endcase

		if (pos >= OFF_LOOP && !loop_over && pos13 >= entry_base) begin
			rel = 32'(pos13 - entry_base);
			if (rel == 32'(ENT_TAG)) begin
				if (cur_type == TYPE_AUDIO) begin
					apid_hold = cur_pid;
				end else if (cur_type == TYPE_VIDEO) begin
					vpid_hold = cur_pid;
				end
				if (cur_type == TYPE_PRIVATE && b == TAG_TELETEXT) ttx_seen = 1'b1;
				if (n_streams != COUNT_MAX) n_streams = n_streams + 8'd1;
				recs[n] = make_record(KIND_ENTRY, cur_type, cur_pid, cur_es_len, b);
				n++;
				entry_base = entry_base + ENT_HDR_LEN + 13'(cur_es_len);
				// with empty ES info the tag byte also opens the next entry
				rel = (pos13 == entry_base) ? 32'(ENT_TYPE) : REL_NONE;
			end
			if (rel == 32'(ENT_TYPE)) begin
				if (32'(entry_base) + 32'(ENT_HDR_LEN) < 32'(slen_hold)) cur_type = b;
				else loop_over = 1'b1;
			end else if (rel == 32'(ENT_PID_HI)) begin
				cur_pid = {b[4:0], 8'h00};
			end else if (rel == 32'(ENT_PID_LO)) begin
				cur_pid = cur_pid | 13'(b);
			end else if (rel == 32'(ENT_LEN_HI)) begin
				cur_es_len = {b[3:0], 8'h00};
			end else if (rel == 32'(ENT_LEN_LO)) begin
				cur_es_len = cur_es_len | 12'(b);
			end
		end

		if (fin) begin
			recs[n] = make_record(KIND_SUMMARY, '0, '0, '0, '0);
			n++;
			pos = '0;
		end else if (pos != OFF_MAX) begin
			pos = pos + 12'd1;
		end

		if (n > 0) recs[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) begin
			expected_records.push_back(recs[i]);
		end
	endtask

	task automatic report(input string msg);
		err_count++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic compare_field(input string fname, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) report($sformatf("%s got 0x%0h expected 0x%0h", fname, got, want));
	endtask

	task automatic check_record();
		rec_t want;
		if (expected_records.size() == 0) begin
			report("output transaction with no record expected");
			return;
		end
		want = expected_records.pop_front();
		compare_field("record_kind",    16'(m_tuser),          16'(want.kind));
		compare_field("last_of_run",    16'(m_tlast),          16'(want.last));
		compare_field("stream_type",    16'(m_tdata[7:0]),     16'(want.stype));
		compare_field("elementary_pid", 16'(m_tdata[20:8]),    16'(want.pid));
		compare_field("es_info_length", 16'(m_tdata[32:21]),   16'(want.es_len));
		compare_field("descriptor_tag", 16'(m_tdata[40:33]),   16'(want.tag));
		compare_field("program_number", 16'(m_tdata[56:41]),   16'(want.prog));
		compare_field("section_length", 16'(m_tdata[68:57]),   16'(want.slen));
		compare_field("audio_pid",      16'(m_tdata[81:69]),   16'(want.apid));
		compare_field("video_pid",      16'(m_tdata[94:82]),   16'(want.vpid));
		compare_field("has_teletext",   16'(m_tdata[95]),      16'(want.ttx));
		compare_field("stream_count",   16'(m_tdata[103:96]),  16'(want.cnt));
	endtask

	// queues one section, last byte flagged
	task automatic push_run(input logic [7:0] bytes[$]);
		for (int i = 0; i < bytes.size(); i++) begin
			pending_bytes.push_back(sec_byte_t'{b: bytes[i], fin: (i == bytes.size() - 1)});
		end
		total_bytes += bytes.size();
	endtask

	function automatic logic [7:0] pick_stream_type();
		case ($urandom_range(0, 6))
			0: return TYPE_VIDEO;
			1: return TYPE_AUDIO;
			2, 3: return TYPE_PRIVATE;
			4: return TAG_TELETEXT;    // doubles as the tag of a preceding empty-info entry
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_pmt_section();
		logic [7:0]  sec[$];
		logic [7:0]  body[$];
		logic [11:0] slen;
		logic [12:0] pid;
		int          pil;
		int          n_ent;
		int          es;
		int          shape;
		bit          cut_short;
		pil = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 2);
		repeat (pil) body.push_back(8'($urandom));
		n_ent = $urandom_range(0, 6);
		cut_short = 1'b0;
		for (int i = 0; i < n_ent && !cut_short; i++) begin
			pid = 13'($urandom);
			es = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
			// rare huge ES info; section ends right after its first descriptor byte
			if ($urandom_range(0, 24) == 0) begin
				es = $urandom_range(0, 1) ? 4095 : $urandom_range(6, 4095);
				cut_short = 1'b1;
			end
			body.push_back(pick_stream_type());
			body.push_back({3'($urandom), pid[12:8]});
			body.push_back(pid[7:0]);
			body.push_back({4'($urandom), 4'(es >> 8)});
			body.push_back(8'(es));
			for (int d = 0; d < (cut_short ? 1 : es); d++) begin
				body.push_back((d == 0 && $urandom_range(0, 1)) ? TAG_TELETEXT : 8'($urandom));
			end
		end

		slen = 12'(body.size() + 13);
		shape = $urandom_range(0, 9);
		if (shape == 7) slen = slen + 12'($urandom_range(0, 12)) - 12'd6;
		sec.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : PMT_TABLE_ID);
		sec.push_back({4'($urandom), slen[11:8]});
		sec.push_back(slen[7:0]);
		repeat (7) sec.push_back(8'($urandom));
		sec.push_back({4'($urandom), 4'(pil >> 8)});
		sec.push_back(8'(pil));
		sec = {sec, body};
		if (!cut_short) begin
			repeat (4) sec.push_back(8'($urandom));    // CRC, not checked by the block
		end
		if (shape == 8) sec = sec[0:$urandom_range(0, sec.size() - 1)];
		push_run(sec);
	endtask

	task automatic add_noise();
		logic [7:0] sec[$];
		repeat ($urandom_range(1, 40)) sec.push_back(8'($urandom));
		push_run(sec);
	endtask

	// max section length and enough empty-info entries to saturate the count
	task automatic add_long_section();
		logic [7:0]  sec[$];
		logic [12:0] pid;
		sec = {PMT_TABLE_ID, {4'($urandom), 4'hF}, 8'hFF};
		repeat (7) sec.push_back(8'($urandom));
		sec.push_back({4'($urandom), 4'h0});
		sec.push_back(8'h00);
		repeat (LONG_ENTRIES) begin
			pid = 13'($urandom);
			sec.push_back(pick_stream_type());
			sec.push_back({3'($urandom), pid[12:8]});
			sec.push_back(pid[7:0]);
			sec.push_back({4'($urandom), 4'h0});
			sec.push_back(8'h00);
		end
		repeat (4) sec.push_back(8'($urandom));
		push_run(sec);
	endtask

	task automatic add_directed();
		// video entry with max PID, then a private entry whose tag is the teletext tag,
		// arriving on the last byte: entry record and summary from one byte
		push_run('{PMT_TABLE_ID, 8'hF0, 8'h18, 8'hFF, 8'hFF, 8'hC1, 8'h00, 8'h00, 8'hE1,
			8'h00, 8'hF0, 8'h00,
			TYPE_VIDEO, 8'hFF, 8'hFF, 8'hF0, 8'h00,
			TYPE_PRIVATE, 8'hE0, 8'h00, 8'hF0, 8'h00,
			TAG_TELETEXT});
		// a section that ends on its table id
		push_run('{8'h00});
	endtask

	always @(posedge clk or negedge arst_n) begin : drive
		sec_byte_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_section_byte(s_tdata, s_tlast);
				bytes_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					item = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= item.b;
					s_tlast <= item.fin;
					if (tx_burst > 1) begin
						tx_burst--;
					end else begin
						tx_burst = $urandom_range(1, 32);
						tx_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_record();
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(64, 256);
				rx_pat = 8'($urandom) | 8'h01;
			end
			rx_left--;
			rx_phase++;
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= rx_pat[rx_phase % 8];
			endcase
		end
	end

	initial begin
		int base;
		add_directed();
		add_long_section();
		base = total_bytes;
		while (total_bytes - base < RANDOM_BYTES) begin
			if ($urandom_range(0, 9) < 8) add_pmt_section();
			else add_noise();
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (bytes_accepted < total_bytes) @(posedge clk);
		while (expected_records.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && expected_records.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

	initial begin
		#(12_000_000);
		$display("testbench failed");
		$finish;
	end

endmodule

// ===== sim.f =====
src/pmt_sp_pkg.sv
src/pmt_sp_core.sv
src/pmt_sp_outbuf.sv
src/pmt_sp_top.sv
dv/testbench.sv
